// ----- design/pcot_pkg.sv -----
// ----------------------------------------------------------------------------
// pcot_pkg
// Shared types and constants of the peer clock offset tracker.
// ----------------------------------------------------------------------------
package pcot_pkg;

  // Default number of peer records
  localparam int unsigned NumPeersDef = 8;

  // Stream and configuration widths
  localparam int unsigned InDataW  = 136;
  localparam int unsigned OutDataW = 72;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Drift quotient: 33-bit numerator, one bit per divider step
  localparam int unsigned DivBits = 33;
  localparam int unsigned DivCntW = $clog2(DivBits);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgOwnNumber    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLowestPlayer = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDriftDivider = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxDelay     = 2'd3;

  // Configuration reset values
  localparam logic [3:0]  OwnNumberRst    = 4'd1;
  localparam logic [3:0]  LowestPlayerRst = 4'd1;
  localparam logic [15:0] DriftDividerRst = 16'd100;
  localparam logic [15:0] MaxDelayRst     = 16'd100;

  // Item function codes
  localparam logic FuncValidate = 1'b0;
  localparam logic FuncMeasure  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic setup;
    logic div_step;
    logic ev1;
    logic ev2;
    logic ev3;
    logic write;
  } pcot_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_range;
    logic out_stall;
  } pcot_sts_t;

endpackage

// ----- design/pcot_ctrl.sv -----
// ----------------------------------------------------------------------------
// pcot_ctrl
// Sequencer of the tracker: accept, setup, drift division, evaluation, write.
// ----------------------------------------------------------------------------
module pcot_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  pcot_pkg::pcot_sts_t sts_i,
  output pcot_pkg::pcot_cmd_t cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSetup = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StEv1   = 3'd3;
  localparam logic [2:0] StEv2   = 3'd4;
  localparam logic [2:0] StEv3   = 3'd5;
  localparam logic [2:0] StWrite = 3'd6;

  localparam logic [pcot_pkg::DivCntW-1:0] DivLast =
    pcot_pkg::DivCntW'(pcot_pkg::DivBits - 1);

  logic [2:0]                   state_q, state_d;
  logic [pcot_pkg::DivCntW-1:0] cnt_q, cnt_d;

  // Next state and step counter
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: begin
        if (s_tvalid_i) state_d = StSetup;
      end
      StSetup: begin
        cnt_d   = '0;
        state_d = sts_i.in_range ? StDiv : StWrite;
      end
      StDiv: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivLast) state_d = StEv1;
      end
      StEv1:   state_d = StEv2;
      StEv2:   state_d = StEv3;
      StEv3:   state_d = StWrite;
      StWrite: begin
        if (!sts_i.out_stall) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Decode commands
  assign s_tready_o     = (state_q == StIdle);
  assign cmd_o.load     = (state_q == StIdle) && s_tvalid_i;
  assign cmd_o.setup    = (state_q == StSetup);
  assign cmd_o.div_step = (state_q == StDiv);
  assign cmd_o.ev1      = (state_q == StEv1);
  assign cmd_o.ev2      = (state_q == StEv2);
  assign cmd_o.ev3      = (state_q == StEv3);
  assign cmd_o.write    = (state_q == StWrite) && !sts_i.out_stall;

endmodule

// ----- design/pcot_dpath.sv -----
// ----------------------------------------------------------------------------
// pcot_dpath
// Peer records, configuration, serial drift divider, window and offset math.
// ----------------------------------------------------------------------------
module pcot_dpath #(
  parameter int unsigned NUM_PEERS = pcot_pkg::NumPeersDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pcot_pkg::pcot_cmd_t             cmd_i,
  output pcot_pkg::pcot_sts_t             sts_o,
  input  logic                            cfg_we_i,
  input  logic [pcot_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pcot_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                            func_i,
  input  logic [pcot_pkg::InDataW-1:0]    s_tdata_i,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [pcot_pkg::OutDataW-1:0]   m_tdata_o
);

  localparam int unsigned IdxW = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
  localparam logic [4:0]  NumPeersV = 5'(NUM_PEERS);

  // Configuration registers
  logic [3:0]  own_q, lowest_q;
  logic [15:0] cdd_q, mpd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q    <= pcot_pkg::OwnNumberRst;
      lowest_q <= pcot_pkg::LowestPlayerRst;
      cdd_q    <= pcot_pkg::DriftDividerRst;
      mpd_q    <= pcot_pkg::MaxDelayRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pcot_pkg::CfgOwnNumber:    own_q    <= cfg_wdata_i[3:0];
        pcot_pkg::CfgLowestPlayer: lowest_q <= cfg_wdata_i[3:0];
        pcot_pkg::CfgDriftDivider: cdd_q    <= cfg_wdata_i;
        pcot_pkg::CfgMaxDelay:     mpd_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Latch the accepted word
  logic        func_q;
  logic [3:0]  sender_q, rcvr_q;
  logic [31:0] send_q, recv_q, orig_q, rcpt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= func_i;
      sender_q <= s_tdata_i[3:0];
      send_q   <= s_tdata_i[35:4];
      recv_q   <= s_tdata_i[67:36];
      rcvr_q   <= s_tdata_i[71:68];
      orig_q   <= s_tdata_i[103:72];
      rcpt_q   <= s_tdata_i[135:104];
    end
  end

  // Map sender to a record index
  logic [3:0] pdiff;
  logic       in_range;
  assign pdiff    = sender_q - lowest_q;
  assign in_range = (sender_q >= lowest_q) && ({1'b0, pdiff} < NumPeersV);

  // Peer records
  logic [31:0] off_mem_q   [NUM_PEERS];
  logic [31:0] rt_mem_q    [NUM_PEERS];
  logic [31:0] stamp_mem_q [NUM_PEERS];

  logic [IdxW-1:0] idx_q;
  logic [31:0]     rd_off, rd_rt, rd_stamp;
  assign rd_off   = off_mem_q[pdiff[IdxW-1:0]];
  assign rd_rt    = rt_mem_q[pdiff[IdxW-1:0]];
  assign rd_stamp = stamp_mem_q[pdiff[IdxW-1:0]];

  // Setup: read record, form differences, load divider
  logic        in_range_q, chk_q;
  logic [31:0] off_q, rt_q, stamp_q, exact_q, half_q;
  logic [31:0] a1_q, a2_q, total_q, proc_q;
  logic [32:0] half_sum;
  logic [31:0] elapsed;
  assign half_sum = {1'b0, rd_rt} + 33'd1;
  assign elapsed  = recv_q - rd_stamp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_range_q <= 1'b0;
    end else if (cmd_i.setup) begin
      in_range_q <= in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      idx_q   <= pdiff[IdxW-1:0];
      off_q   <= rd_off;
      rt_q    <= rd_rt;
      stamp_q <= rd_stamp;
      exact_q <= recv_q + rd_off;
      half_q  <= half_sum[32:1];
      a1_q    <= rcpt_q - orig_q;
      a2_q    <= send_q - recv_q;
      total_q <= recv_q - orig_q;
      proc_q  <= send_q - rcpt_q;
      chk_q   <= (rcvr_q == own_q) && (recv_q >= orig_q) && (send_q >= rcpt_q);
    end
  end

  // Restoring divider: (2 * elapsed) / divider, one quotient bit per step
  logic [32:0] quo_q;
  logic [16:0] rem_q;
  logic [15:0] dvs_q;
  logic [16:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = {rem_q[15:0], quo_q[32]};
  assign rem_ge = (rem_sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      quo_q <= {elapsed, 1'b0};
      rem_q <= '0;
      dvs_q <= (cdd_q == '0) ? 16'd1 : cdd_q;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[31:0], rem_ge};
      rem_q <= rem_ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
    end
  end

  // Evaluation stage 1: error bound, doubled drift, raw offset sum
  logic [31:0] b32_q, exm_q, sum_q, nrt_q;
  logic [35:0] t1_q;
  logic        used_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ev1) begin
      b32_q  <= half_q + quo_q[31:0];
      t1_q   <= {4'b0, rt_q} + {2'b0, quo_q, 1'b0};
      exm_q  <= exact_q - {16'b0, mpd_q};
      sum_q  <= a1_q + a2_q;
      nrt_q  <= total_q - proc_q;
      used_q <= chk_q && (proc_q <= total_q);
    end
  end

  // Evaluation stage 2: window edges, halved offset, round trip tests
  logic [31:0] hi_q, lo_q, noff_q;
  logic [36:0] rhs_q;
  logic        lt_q;
  logic [31:0] sum_adj;
  assign sum_adj = sum_q + {31'b0, sum_q[31]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.ev2) begin
      hi_q   <= exact_q + b32_q;
      lo_q   <= exm_q - b32_q;
      noff_q <= {sum_adj[31], sum_adj[31:1]};
      lt_q   <= ({4'b0, nrt_q} < t1_q);
      rhs_q  <= {5'b0, nrt_q} + {1'b0, t1_q};
    end
  end

  // Evaluation stage 3: offset difference, window check
  logic [32:0] diff_q;
  logic        outwin_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ev3) begin
      diff_q   <= {noff_q[31], noff_q} - {off_q[31], off_q};
      outwin_q <= (send_q < lo_q) || (send_q > hi_q);
    end
  end

  // Decide replacement or invalidation
  logic [33:0] dbl;
  logic [38:0] neg_sum;
  logic        incons, replace, invalid, rec_we;
  logic [31:0] new_off, new_rt, new_stamp;

  assign dbl     = {diff_q, 1'b0};
  assign neg_sum = {{5{dbl[33]}}, dbl} + {2'b0, rhs_q};
  assign incons  = diff_q[32] ? neg_sum[38] : ({3'b0, dbl} > rhs_q);

  assign replace = in_range_q && (func_q == pcot_pkg::FuncMeasure) && used_q &&
                   ((stamp_q == '0) || lt_q || incons);
  assign invalid = in_range_q && (func_q == pcot_pkg::FuncValidate) &&
                   (stamp_q != '0) && outwin_q;
  assign rec_we  = cmd_i.write && (replace || invalid);

  assign new_off   = replace ? noff_q : off_q;
  assign new_rt    = replace ? nrt_q : rt_q;
  assign new_stamp = replace ? recv_q : (invalid ? 32'd0 : stamp_q);

  // Write back the record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PEERS; i++) begin
        off_mem_q[i]   <= '0;
        rt_mem_q[i]    <= '0;
        stamp_mem_q[i] <= '0;
      end
    end else if (rec_we) begin
      off_mem_q[idx_q]   <= new_off;
      rt_mem_q[idx_q]    <= new_rt;
      stamp_mem_q[idx_q] <= new_stamp;
    end
  end

  // Output register
  logic                          m_valid_q;
  logic [pcot_pkg::OutDataW-1:0] m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.write) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      m_data_q <= {4'b0,
                   in_range_q ? new_rt : 32'd0,
                   in_range_q ? new_off : 32'd0,
                   replace,
                   in_range_q && (func_q == pcot_pkg::FuncMeasure) && used_q,
                   in_range_q && (new_stamp == '0),
                   in_range_q && (new_stamp != '0)};
    end
  end

  assign m_tvalid_o      = m_valid_q;
  assign m_tdata_o       = m_data_q;
  assign sts_o.in_range  = in_range;
  assign sts_o.out_stall = m_valid_q && !m_tready_i;

`ifndef SYNTH
  // Divider remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> (rem_q < {1'b0, dvs_q}))
    else $error("divider remainder not below divisor");

  // Records change only for senders in range
  a_rec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_we |-> in_range_q)
    else $error("record written for out of range sender");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write |-> !(m_valid_q && !m_tready_i))
    else $error("result written while output stalled");
`endif

endmodule

// ----- design/peer_clock_offset_tracker_core.sv -----
// ----------------------------------------------------------------------------
// peer_clock_offset_tracker_core
// Per-peer clock offset and round trip tracker with header validation.
// ----------------------------------------------------------------------------
// Latency: the result word is registered after the input word is taken, once
// setup, the bit-serial drift divider (one quotient bit per cycle), the
// evaluation stages and the write are through; a sender outside the peer range goes from setup straight to the write.
// Throughput: one item in flight at a time; a new word is taken only after the last result is written.
// Reset: all peer records cleared to invalid at once, configuration
// registers return to their defaults, output queue empty.
module peer_clock_offset_tracker_core #(
  parameter int unsigned NUM_PEERS = pcot_pkg::NumPeersDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input word: sender_id, send_time, receive_time, entry_receiver,
  // request_origination, request_receipt
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [pcot_pkg::InDataW-1:0]  s_axis_tdata_i,
  // tuser: func
  input  logic [0:0]                    s_axis_tuser_i,
  // Result word: peer_valid, request_sync, measurement_used,
  // record_replaced, clock_offset, round_trip_time, zero fill
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [pcot_pkg::OutDataW-1:0] m_axis_tdata_o,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [pcot_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pcot_pkg::CfgDataW-1:0] cfg_wdata_i
);

  pcot_pkg::pcot_cmd_t cmd;
  pcot_pkg::pcot_sts_t sts;

  // Sequencer
  pcot_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Records and arithmetic
  pcot_dpath #(
    .NUM_PEERS (NUM_PEERS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .func_i      (s_axis_tuser_i[0]),
    .s_tdata_i   (s_axis_tdata_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o)
  );

endmodule
